/* src/stbs_pkg.sv */
package stbs_pkg;

    localparam int CMD_W     = 3;
    localparam int WIDX_W    = 10;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 10;
    localparam int COUNT_W   = 11;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // s_tdata layout
    localparam int WIDX_LSB  = 0;
    localparam int VALUE_LSB = WIDX_LSB + WIDX_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 3'd0,
        CMD_ANY_EQ   = 3'd1,
        CMD_FIRST_EQ = 3'd2,
        CMD_LAST_EQ  = 3'd3,
        CMD_FIRST_GE = 3'd4,
        CMD_FIRST_GT = 3'd5,
        CMD_LAST_LE  = 3'd6,
        CMD_LAST_LT  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_READ   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    localparam logic REG_ENTRY_COUNT = 1'b0;

endpackage

/* src/sorted_table_binary_search_unit.sv */
// Sorted-table search unit. Software fills the table in ascending (signed) order with write
// requests (s_tuser = 0), sets entry_count over APB at byte address 0, and then issues query
// requests; each query returns one response with found on m_tuser and the position on
// m_tdata, while a write returns nothing. Table contents are undefined after reset and there
// is no clearing pass: every entry below entry_count must be written before it is searched.
// A query searches the active count of entries (entry_count capped at TABLE_DEPTH): it is
// accepted, then probes the single-read-port table memory once per search step, then posts
// its response once the response register is free. One request is in flight at a time; a
// pending response does not block the next request from being accepted.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stbs_pkg::APB_AW-1:0]    paddr,
    input  logic [stbs_pkg::APB_DW-1:0]    pwdata,
    output logic [stbs_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stbs_pkg::S_TDATA_W-1:0] s_tdata,  // write_index[9:0], value[41:10], zeros
    input  logic [stbs_pkg::CMD_W-1:0]     s_tuser,  // command[2:0]
    // response channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [stbs_pkg::M_TDATA_W-1:0] m_tdata,  // position[9:0], zeros
    output logic                           m_tuser   // found
);
    import stbs_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // table memory
    logic signed [DATA_WIDTH-1:0] mem_store [TABLE_DEPTH];
    logic signed [DATA_WIDTH-1:0] rd_data_reg;
    logic                         wr_en;
    logic [IW-1:0]                wr_addr;
    logic                         probe_en;

    // control
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // search payload
    cmd_t                    cmd_reg, cmd_next;
    logic                    strict_reg, strict_next;
    logic signed [DATA_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           hi_reg, hi_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic                    eq_left_reg, eq_left_next;
    logic                    eq_right_reg, eq_right_next;
    logic                    hit_reg, hit_next;
    logic                    found_reg, found_next;
    logic [POS_W-1:0]        pos_reg, pos_next;

    // request decode
    cmd_t                    in_cmd;
    logic [WIDX_W-1:0]       in_widx;
    logic signed [VALUE_W-1:0] in_value;
    logic signed [DATA_WIDTH-1:0] in_key;
    logic [31:0]             widx_ext;
    logic [31:0]             cnt_ext;
    logic [CW-1:0]           active_n;
    logic                    s_accept;

    // probe evaluation
    logic                    e_eq, e_gt, go_left;
    logic [CW-1:0]           mid_left, mid_right, mid_plus1;

    // result
    logic                    res_found;
    logic [CW-1:0]           res_pos;
    logic                    out_free;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_widx  = s_tdata[WIDX_LSB +: WIDX_W];
    assign in_value = s_tdata[VALUE_LSB +: VALUE_W];
    assign in_key   = DATA_WIDTH'(in_value);
    assign widx_ext = 32'(in_widx);
    assign cnt_ext  = 32'(count_reg);
    assign active_n = (cnt_ext > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext[CW-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign wr_en   = s_accept && (in_cmd == CMD_WRITE) && (widx_ext < 32'(TABLE_DEPTH));
    assign wr_addr = widx_ext[IW-1:0];

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? APB_DW'(count_reg) : '0;

    // probe compare and both candidate next midpoints
    assign e_eq      = (rd_data_reg == key_reg);
    assign e_gt      = (rd_data_reg > key_reg);
    assign go_left   = strict_reg ? e_gt : (e_gt || e_eq);
    assign mid_plus1 = mid_reg + CW'(1);
    assign mid_left  = lo_reg + ((mid_reg - lo_reg - CW'(1)) >> 1);
    assign mid_right = mid_plus1 + ((hi_reg - mid_reg - CW'(2)) >> 1);

    // final answer from the converged bound
    always_comb begin
        res_found = 1'b0;
        res_pos   = lo_reg;
        unique case (cmd_reg)
            CMD_WRITE: begin
                res_found = 1'b0;
            end
            CMD_ANY_EQ: begin
                res_found = hit_reg;
                res_pos   = mid_reg;
            end
            CMD_FIRST_EQ: begin
                // entry at the lower bound was the last probe that moved hi
                res_found = (lo_reg < n_reg) && eq_left_reg;
            end
            CMD_LAST_EQ: begin
                // entry at upper bound minus one was the last probe that moved lo
                res_found = (lo_reg != '0) && eq_right_reg;
                res_pos   = lo_reg - CW'(1);
            end
            CMD_FIRST_GE, CMD_FIRST_GT: begin
                res_found = (lo_reg < n_reg);
            end
            CMD_LAST_LE, CMD_LAST_LT: begin
                res_found = (lo_reg != '0);
                res_pos   = lo_reg - CW'(1);
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd_next      = cmd_reg;
        strict_next   = strict_reg;
        key_next      = key_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        eq_left_next  = eq_left_reg;
        eq_right_next = eq_right_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        pos_next      = pos_reg;
        probe_en      = 1'b0;

        if (psel && penable && pwrite && pready && (paddr[2] == REG_ENTRY_COUNT)) begin
            count_next = pwdata[COUNT_W-1:0];
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_cmd != CMD_WRITE)) begin
                    cmd_next      = in_cmd;
                    strict_next   = (in_cmd == CMD_ANY_EQ) || (in_cmd == CMD_LAST_EQ) ||
                                    (in_cmd == CMD_FIRST_GT) || (in_cmd == CMD_LAST_LE);
                    key_next      = in_key;
                    n_next        = active_n;
                    lo_next       = '0;
                    hi_next       = active_n;
                    mid_next      = (active_n - CW'(1)) >> 1;
                    eq_left_next  = 1'b0;
                    eq_right_next = 1'b0;
                    hit_next      = 1'b0;
                    if (active_n == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        probe_en   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if ((cmd_reg == CMD_ANY_EQ) && e_eq) begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if (go_left) begin
                    hi_next      = mid_reg;
                    eq_left_next = e_eq;
                    if (mid_reg > lo_reg) begin
                        mid_next = mid_left;
                        probe_en = 1'b1;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    lo_next       = mid_plus1;
                    eq_right_next = e_eq;
                    if (mid_plus1 < hi_reg) begin
                        mid_next = mid_right;
                        probe_en = 1'b1;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    found_next    = res_found;
                    pos_next      = res_found ? POS_W'(res_pos) : '0;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_store[wr_addr] <= in_key;
        end
        if (probe_en) begin
            rd_data_reg <= mem_store[mid_next[IW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            cmd_reg      <= CMD_WRITE;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            cmd_reg      <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        strict_reg   <= strict_next;
        key_reg      <= key_next;
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        eq_left_reg  <= eq_left_next;
        eq_right_reg <= eq_right_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = M_TDATA_W'(pos_reg);

endmodule
